/* sv/cpu65_pkg.sv */
// Shared types, constants and decode functions for the 6502 core.
// Holds the transaction structs, opcode decode and ALU helper functions.
// Depends on nothing; used by cpu_6502_core_top.
package cpu65_pkg;

   typedef struct packed {
      logic       action;
      logic [7:0] read_data;
      logic       nmi_request;
      logic       irq_request;
   } req_type;

   typedef struct packed {
      logic [15:0] bus_address;
      logic [7:0]  bus_write_data;
      logic        bus_is_write;
      logic        last_access;
      logic        instr_done;
      logic [3:0]  instr_cycles;
      logic        bad_opcode;
      logic        nmi_taken;
      logic        irq_taken;
   } rsp_type;

   typedef enum logic [10:0] {
      PH_VLO = 11'b000_0000_0001,
      PH_VHI = 11'b000_0000_0010,
      PH_OPC = 11'b000_0000_0100,
      PH_OP1 = 11'b000_0000_1000,
      PH_OP2 = 11'b000_0001_0000,
      PH_PLO = 11'b000_0010_0000,
      PH_PHI = 11'b000_0100_0000,
      PH_DAT = 11'b000_1000_0000,
      PH_PL1 = 11'b001_0000_0000,
      PH_PL2 = 11'b010_0000_0000,
      PH_PL3 = 11'b100_0000_0000
   } phase_type;

   typedef logic [3:0] mode_type;
   localparam mode_type M_IMP = 4'd0;
   localparam mode_type M_IMM = 4'd1;
   localparam mode_type M_ZP  = 4'd2;
   localparam mode_type M_ZPX = 4'd3;
   localparam mode_type M_ZPY = 4'd4;
   localparam mode_type M_ABS = 4'd5;
   localparam mode_type M_ABX = 4'd6;
   localparam mode_type M_ABY = 4'd7;
   localparam mode_type M_IZX = 4'd8;
   localparam mode_type M_IZY = 4'd9;
   localparam mode_type M_REL = 4'd10;
   localparam mode_type M_IND = 4'd11;

   typedef logic [5:0] kind_type;
   localparam kind_type K_ORA = 6'd0;
   localparam kind_type K_AND = 6'd1;
   localparam kind_type K_EOR = 6'd2;
   localparam kind_type K_ADC = 6'd3;
   localparam kind_type K_STA = 6'd4;
   localparam kind_type K_LDA = 6'd5;
   localparam kind_type K_CMP = 6'd6;
   localparam kind_type K_SBC = 6'd7;
   localparam kind_type K_ASL = 6'd8;
   localparam kind_type K_ROL = 6'd9;
   localparam kind_type K_LSR = 6'd10;
   localparam kind_type K_ROR = 6'd11;
   localparam kind_type K_STX = 6'd12;
   localparam kind_type K_LDX = 6'd13;
   localparam kind_type K_DEC = 6'd14;
   localparam kind_type K_INC = 6'd15;
   localparam kind_type K_BIT = 6'd16;
   localparam kind_type K_STY = 6'd17;
   localparam kind_type K_LDY = 6'd18;
   localparam kind_type K_CPY = 6'd19;
   localparam kind_type K_CPX = 6'd20;
   localparam kind_type K_JMP = 6'd21;
   localparam kind_type K_JSR = 6'd22;
   localparam kind_type K_BRK = 6'd23;
   localparam kind_type K_RTI = 6'd24;
   localparam kind_type K_RTS = 6'd25;
   localparam kind_type K_PHP = 6'd26;
   localparam kind_type K_PLP = 6'd27;
   localparam kind_type K_PHA = 6'd28;
   localparam kind_type K_PLA = 6'd29;
   localparam kind_type K_BR  = 6'd30;
   localparam kind_type K_CLC = 6'd31;
   localparam kind_type K_SEC = 6'd32;
   localparam kind_type K_CLI = 6'd33;
   localparam kind_type K_SEI = 6'd34;
   localparam kind_type K_CLV = 6'd35;
   localparam kind_type K_CLD = 6'd36;
   localparam kind_type K_SED = 6'd37;
   localparam kind_type K_TXA = 6'd38;
   localparam kind_type K_TYA = 6'd39;
   localparam kind_type K_TXS = 6'd40;
   localparam kind_type K_TAY = 6'd41;
   localparam kind_type K_TAX = 6'd42;
   localparam kind_type K_TSX = 6'd43;
   localparam kind_type K_DEX = 6'd44;
   localparam kind_type K_DEY = 6'd45;
   localparam kind_type K_INX = 6'd46;
   localparam kind_type K_INY = 6'd47;
   localparam kind_type K_NOP = 6'd48;

   localparam logic [15:0] RESET_VECTOR = 16'hfffc;
   localparam logic [15:0] NMI_VECTOR   = 16'hfffa;
   localparam logic [15:0] IRQ_VECTOR   = 16'hfffe;
   localparam logic [7:0]  SP_RESET     = 8'hfd;
   localparam logic [7:0]  P_RESET      = 8'h34;
   localparam logic [7:0]  STACK_PAGE   = 8'h01;

   typedef struct packed {
      logic       valid;
      mode_type   mode;
      kind_type   kind;
      logic [3:0] cycles;
   } dec_type;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] p;
   } regs_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] p;
   } mod_type;

   typedef struct packed {
      logic [1:0]       wr_cnt;
      logic [3:0][15:0] wr_addr;
      logic [3:0][7:0]  wr_data;
      logic [15:0]      rd_addr;
      logic             done;
      logic [3:0]       cyc;
      logic             bad;
      logic             nmi;
      logic             irq;
   } run_type;

   function automatic dec_type decode(input logic [7:0] op);
      dec_type    r;
      logic [2:0] a;
      logic [2:0] b;
      r = '0;
      r.valid = 1'b1;
      a = op[7:5];
      b = op[4:2];
      case (op[1:0])
         2'd1: begin
            r.kind = {3'b000, a};
            r.cycles = 4'd4;
            case (b)
               3'd0: begin r.mode = M_IZX; r.cycles = 4'd6; end
               3'd1: begin r.mode = M_ZP;  r.cycles = 4'd3; end
               3'd2: begin r.mode = M_IMM; r.cycles = 4'd2; end
               3'd3: r.mode = M_ABS;
               3'd4: begin
                  r.mode = M_IZY;
                  r.cycles = (a == 3'd4) ? 4'd6 : 4'd5;
               end
               3'd5: r.mode = M_ZPX;
               3'd6: r.mode = M_ABY;
               default: r.mode = M_ABX;
            endcase
            if (op == 8'h89) begin
               r.valid = 1'b0;
            end
         end
         2'd2: begin
            r.kind = {3'b001, a};
            case (b)
               3'd0: begin
                  r.mode = M_IMM;
                  r.cycles = 4'd2;
                  r.valid = (op == 8'ha2);
               end
               3'd1: begin
                  r.mode = M_ZP;
                  r.cycles = (a == 3'd4 || a == 3'd5) ? 4'd3 : 4'd5;
               end
               3'd2: begin
                  r.mode = M_IMP;
                  r.cycles = 4'd2;
                  case (a)
                     3'd4: r.kind = K_TXA;
                     3'd5: r.kind = K_TAX;
                     3'd6: r.kind = K_DEX;
                     3'd7: r.kind = K_NOP;
                     default: r.kind = {3'b001, a};
                  endcase
               end
               3'd3: begin
                  r.mode = M_ABS;
                  r.cycles = (a == 3'd4 || a == 3'd5) ? 4'd4 : 4'd6;
               end
               3'd5: begin
                  if (a == 3'd4 || a == 3'd5) begin
                     r.mode = M_ZPY;
                     r.cycles = 4'd4;
                  end else begin
                     r.mode = M_ZPX;
                     r.cycles = 4'd6;
                  end
               end
               3'd6: begin
                  r.mode = M_IMP;
                  r.cycles = 4'd2;
                  if (op == 8'h9a) begin
                     r.kind = K_TXS;
                  end else if (op == 8'hba) begin
                     r.kind = K_TSX;
                  end else begin
                     r.valid = 1'b0;
                  end
               end
               3'd7: begin
                  if (a == 3'd4) begin
                     r.valid = 1'b0;
                  end else if (a == 3'd5) begin
                     r.mode = M_ABY;
                     r.cycles = 4'd4;
                  end else begin
                     r.mode = M_ABX;
                     r.cycles = (a < 3'd4) ? 4'd6 : 4'd7;
                  end
               end
               default: r.valid = 1'b0;
            endcase
         end
         2'd0: begin
            r.mode = M_IMP;
            r.cycles = 4'd2;
            if (b == 3'd4) begin
               r.mode = M_REL;
               r.kind = K_BR;
            end else if (b == 3'd6) begin
               case (a)
                  3'd0: r.kind = K_CLC;
                  3'd1: r.kind = K_SEC;
                  3'd2: r.kind = K_CLI;
                  3'd3: r.kind = K_SEI;
                  3'd4: r.kind = K_TYA;
                  3'd5: r.kind = K_CLV;
                  3'd6: r.kind = K_CLD;
                  default: r.kind = K_SED;
               endcase
            end else if (b == 3'd2) begin
               case (a)
                  3'd0: begin r.kind = K_PHP; r.cycles = 4'd3; end
                  3'd1: begin r.kind = K_PLP; r.cycles = 4'd4; end
                  3'd2: begin r.kind = K_PHA; r.cycles = 4'd3; end
                  3'd3: begin r.kind = K_PLA; r.cycles = 4'd4; end
                  3'd4: r.kind = K_DEY;
                  3'd5: r.kind = K_TAY;
                  3'd6: r.kind = K_INY;
                  default: r.kind = K_INX;
               endcase
            end else if (b == 3'd0) begin
               case (a)
                  3'd0: begin r.kind = K_BRK; r.cycles = 4'd7; end
                  3'd1: begin r.mode = M_ABS; r.kind = K_JSR; r.cycles = 4'd6; end
                  3'd2: begin r.kind = K_RTI; r.cycles = 4'd6; end
                  3'd3: begin r.kind = K_RTS; r.cycles = 4'd6; end
                  3'd5: begin r.mode = M_IMM; r.kind = K_LDY; end
                  3'd6: begin r.mode = M_IMM; r.kind = K_CPY; end
                  3'd7: begin r.mode = M_IMM; r.kind = K_CPX; end
                  default: r.valid = 1'b0;
               endcase
            end else if (op == 8'h4c) begin
               r.mode = M_ABS;
               r.kind = K_JMP;
               r.cycles = 4'd3;
            end else if (op == 8'h6c) begin
               r.mode = M_IND;
               r.kind = K_JMP;
               r.cycles = 4'd5;
            end else begin
               case (a)
                  3'd1: r.kind = K_BIT;
                  3'd4: r.kind = K_STY;
                  3'd5: r.kind = K_LDY;
                  3'd6: r.kind = K_CPY;
                  3'd7: r.kind = K_CPX;
                  default: r.valid = 1'b0;
               endcase
               if (b == 3'd1) begin
                  r.mode = M_ZP;
                  r.cycles = 4'd3;
               end else if (b == 3'd3) begin
                  r.mode = M_ABS;
                  r.cycles = 4'd4;
               end else if (b == 3'd5 && (a == 3'd4 || a == 3'd5)) begin
                  r.mode = M_ZPX;
                  r.cycles = 4'd4;
               end else if (b == 3'd7 && a == 3'd5) begin
                  r.mode = M_ABX;
                  r.cycles = 4'd4;
               end else begin
                  r.valid = 1'b0;
               end
            end
         end
         default: r.valid = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      return {v[7], p[6:2], (v == 8'h00), p[0]};
   endfunction

   function automatic logic [7:0] compare(input logic [7:0] p, input logic [7:0] r,
                                          input logic [7:0] v);
      logic [7:0] q;
      q = set_nz(p, 8'(r - v));
      q[0] = (r >= v);
      return q;
   endfunction

   function automatic regs_type exec_read(input kind_type kd, input logic [7:0] v,
                                          input regs_type s);
      regs_type   r;
      logic [8:0] sum;
      r = s;
      sum = '0;
      case (kd)
         K_ORA: begin r.a = s.a | v; r.p = set_nz(s.p, r.a); end
         K_AND: begin r.a = s.a & v; r.p = set_nz(s.p, r.a); end
         K_EOR: begin r.a = s.a ^ v; r.p = set_nz(s.p, r.a); end
         K_ADC: begin
            sum = {1'b0, s.a} + {1'b0, v} + {8'h00, s.p[0]};
            r.a = sum[7:0];
            r.p = set_nz(s.p, sum[7:0]);
            r.p[6] = ~(s.a[7] ^ v[7]) & (s.a[7] ^ sum[7]);
            r.p[0] = sum[8];
         end
         K_SBC: begin
            sum = {1'b0, s.a} + {1'b0, ~v} + {8'h00, s.p[0]};
            r.a = sum[7:0];
            r.p = set_nz(s.p, sum[7:0]);
            r.p[6] = (s.a[7] ^ sum[7]) & (s.a[7] ^ v[7]);
            r.p[0] = sum[8];
         end
         K_LDA: begin r.a = v; r.p = set_nz(s.p, v); end
         K_CMP: r.p = compare(s.p, s.a, v);
         K_LDX: begin r.x = v; r.p = set_nz(s.p, v); end
         K_LDY: begin r.y = v; r.p = set_nz(s.p, v); end
         K_CPX: r.p = compare(s.p, s.x, v);
         K_CPY: r.p = compare(s.p, s.y, v);
         K_BIT: begin
            r.p[7:6] = v[7:6];
            r.p[1] = ((s.a & v) == 8'h00);
         end
         default: r = s;
      endcase
      return r;
   endfunction

   function automatic mod_type modify(input kind_type kd, input logic [7:0] v,
                                      input logic [7:0] p);
      mod_type m;
      m.p = p;
      case (kd)
         K_ASL: begin m.r = {v[6:0], 1'b0}; m.p[0] = v[7]; end
         K_ROL: begin m.r = {v[6:0], p[0]}; m.p[0] = v[7]; end
         K_LSR: begin m.r = {1'b0, v[7:1]}; m.p[0] = v[0]; end
         K_ROR: begin m.r = {p[0], v[7:1]}; m.p[0] = v[0]; end
         K_DEC: m.r = v - 8'd1;
         default: m.r = v + 8'd1;
      endcase
      m.p = set_nz(m.p, m.r);
      return m;
   endfunction

endpackage

/* sv/cpu_6502_core_top.sv */
// 6502 core: one register stage per bus read return, then a run buffer of bus accesses.
// A run's first access is shown in the cycle after its request is taken; a run of one
// to four accesses drains one per cycle while rsp_ready is high, and requests are taken
// at that rate for single-read runs, else only with a run's last access, as the result
// port holds one access. Reset is synchronous and puts the core in its power-on state
// with the reset vector low read pending and no result held. Depends on cpu65_pkg.
module cpu_6502_core_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cpu65_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cpu65_pkg::rsp_type  rsp_data
);

   cpu65_pkg::regs_type  regs_ff, regs_in;
   logic [7:0]           sp_ff, sp_in;
   logic [15:0]          pc_ff, pc_in;
   logic [7:0]           op_ff, op_in;
   cpu65_pkg::phase_type ph_ff, ph_in;
   logic [15:0]          oa_ff, oa_in;
   logic [15:0]          pt_ff, pt_in;
   logic [3:0]           tally_ff, tally_in;
   cpu65_pkg::run_type   run_ff, run_in;
   logic                 pend_ff;
   logic [1:0]           idx_ff;

   cpu65_pkg::dec_type   dec_cur, dec_new;
   cpu65_pkg::mod_type   mr;
   logic [7:0]           rd_byte;
   logic [7:0]           zpx_sum, zpy_sum, pt_lo_inc;
   logic [3:0]           cy_sel;
   logic [15:0]          t16, base16, eff16;
   logic                 taken;
   logic                 acc_req, fin_req, ent_req, ent_brk;
   logic [15:0]          acc_addr, ent_vec;
   logic                 last_item;
   logic                 req_take;

   assign rd_byte   = req_data.read_data;
   assign zpx_sum   = rd_byte + regs_ff.x;
   assign zpy_sum   = rd_byte + regs_ff.y;
   assign pt_lo_inc = pt_ff[7:0] + 8'd1;
   assign dec_cur   = cpu65_pkg::decode(op_ff);
   assign dec_new   = cpu65_pkg::decode(rd_byte);

   always_comb begin
      regs_in  = regs_ff;
      sp_in    = sp_ff;
      pc_in    = pc_ff;
      op_in    = op_ff;
      ph_in    = ph_ff;
      oa_in    = oa_ff;
      pt_in    = pt_ff;
      tally_in = tally_ff;
      run_in   = '0;
      cy_sel   = dec_cur.cycles;
      t16      = '0;
      base16   = '0;
      eff16    = '0;
      taken    = 1'b0;
      mr       = '0;
      acc_req  = 1'b0;
      acc_addr = '0;
      fin_req  = 1'b0;
      ent_req  = 1'b0;
      ent_brk  = 1'b0;
      ent_vec  = cpu65_pkg::IRQ_VECTOR;
      if (!req_data.action) begin
         regs_in.a = 8'h00;
         regs_in.x = 8'h00;
         regs_in.y = 8'h00;
         regs_in.p = cpu65_pkg::P_RESET;
         sp_in = cpu65_pkg::SP_RESET;
         pc_in = '0;
         op_in = '0;
         ph_in = cpu65_pkg::PH_VLO;
         oa_in = '0;
         pt_in = cpu65_pkg::RESET_VECTOR;
         tally_in = '0;
         run_in.rd_addr = cpu65_pkg::RESET_VECTOR;
      end else begin
         case (ph_ff)
            cpu65_pkg::PH_VLO: begin
               oa_in = {8'h00, rd_byte};
               run_in.rd_addr = pt_ff + 16'd1;
               ph_in = cpu65_pkg::PH_VHI;
            end
            cpu65_pkg::PH_VHI: begin
               pc_in = {rd_byte, oa_ff[7:0]};
               if (pt_ff == cpu65_pkg::RESET_VECTOR) begin
                  pc_in[15] = 1'b1;
               end else begin
                  run_in.done = 1'b1;
                  run_in.cyc = 4'd7;
               end
               run_in.rd_addr = pc_in;
               ph_in = cpu65_pkg::PH_OPC;
            end
            cpu65_pkg::PH_OP1: begin
               pc_in = pc_ff + 16'd1;
               case (dec_cur.mode)
                  cpu65_pkg::M_IMM: begin
                     regs_in = cpu65_pkg::exec_read(dec_cur.kind, rd_byte, regs_ff);
                     fin_req = 1'b1;
                  end
                  cpu65_pkg::M_ZP: begin
                     acc_req = 1'b1;
                     acc_addr = {8'h00, rd_byte};
                  end
                  cpu65_pkg::M_ZPX: begin
                     acc_req = 1'b1;
                     acc_addr = {8'h00, zpx_sum};
                  end
                  cpu65_pkg::M_ZPY: begin
                     acc_req = 1'b1;
                     acc_addr = {8'h00, zpy_sum};
                  end
                  cpu65_pkg::M_REL: begin
                     t16 = pc_in + {{8{rd_byte[7]}}, rd_byte};
                     if (t16[15:8] != pc_in[15:8]) begin
                        tally_in = tally_in + 4'd1;
                     end
                     case (op_ff[7:6])
                        2'd0: taken = regs_ff.p[7];
                        2'd1: taken = regs_ff.p[6];
                        2'd2: taken = regs_ff.p[0];
                        default: taken = regs_ff.p[1];
                     endcase
                     if (taken == op_ff[5]) begin
                        pc_in = t16;
                        tally_in = tally_in + 4'd1;
                     end
                     fin_req = 1'b1;
                  end
                  cpu65_pkg::M_IZX, cpu65_pkg::M_IZY: begin
                     pt_in = (dec_cur.mode == cpu65_pkg::M_IZX) ? {8'h00, zpx_sum}
                                                                : {8'h00, rd_byte};
                     run_in.rd_addr = pt_in;
                     ph_in = cpu65_pkg::PH_PLO;
                  end
                  default: begin
                     oa_in = {8'h00, rd_byte};
                     run_in.rd_addr = pc_in;
                     ph_in = cpu65_pkg::PH_OP2;
                  end
               endcase
            end
            cpu65_pkg::PH_OP2: begin
               base16 = {rd_byte, oa_ff[7:0]};
               pc_in = pc_ff + 16'd1;
               if (dec_cur.kind == cpu65_pkg::K_JSR) begin
                  t16 = pc_in - 16'd1;
                  run_in.wr_addr[0] = {cpu65_pkg::STACK_PAGE, sp_ff};
                  run_in.wr_data[0] = t16[15:8];
                  run_in.wr_addr[1] = {cpu65_pkg::STACK_PAGE, 8'(sp_ff - 8'd1)};
                  run_in.wr_data[1] = t16[7:0];
                  run_in.wr_cnt = 2'd2;
                  sp_in = sp_ff - 8'd2;
                  pc_in = base16;
                  fin_req = 1'b1;
               end else if (dec_cur.mode == cpu65_pkg::M_IND) begin
                  pt_in = base16;
                  run_in.rd_addr = base16;
                  ph_in = cpu65_pkg::PH_PLO;
               end else if (dec_cur.kind == cpu65_pkg::K_JMP) begin
                  pc_in = base16;
                  fin_req = 1'b1;
               end else if (dec_cur.mode == cpu65_pkg::M_ABX ||
                            dec_cur.mode == cpu65_pkg::M_ABY) begin
                  eff16 = base16 + {8'h00, (dec_cur.mode == cpu65_pkg::M_ABX) ? regs_ff.x
                                                                               : regs_ff.y};
                  if (eff16[15:8] != base16[15:8]) begin
                     tally_in = tally_in + 4'd1;
                  end
                  acc_req = 1'b1;
                  acc_addr = eff16;
               end else begin
                  acc_req = 1'b1;
                  acc_addr = base16;
               end
            end
            cpu65_pkg::PH_PLO: begin
               oa_in = {8'h00, rd_byte};
               run_in.rd_addr = {pt_ff[15:8], pt_lo_inc};
               ph_in = cpu65_pkg::PH_PHI;
            end
            cpu65_pkg::PH_PHI: begin
               base16 = {rd_byte, oa_ff[7:0]};
               if (dec_cur.mode == cpu65_pkg::M_IZX) begin
                  if (base16[15:8] != pt_ff[15:8]) begin
                     tally_in = tally_in + 4'd1;
                  end
                  acc_req = 1'b1;
                  acc_addr = base16;
               end else if (dec_cur.mode == cpu65_pkg::M_IZY) begin
                  eff16 = base16 + {8'h00, regs_ff.y};
                  if (eff16[15:8] != base16[15:8]) begin
                     tally_in = tally_in + 4'd1;
                  end
                  acc_req = 1'b1;
                  acc_addr = eff16;
               end else begin
                  pc_in = base16;
                  fin_req = 1'b1;
               end
            end
            cpu65_pkg::PH_DAT: begin
               if (dec_cur.kind == cpu65_pkg::K_ASL || dec_cur.kind == cpu65_pkg::K_ROL ||
                   dec_cur.kind == cpu65_pkg::K_LSR || dec_cur.kind == cpu65_pkg::K_ROR ||
                   dec_cur.kind == cpu65_pkg::K_DEC || dec_cur.kind == cpu65_pkg::K_INC) begin
                  mr = cpu65_pkg::modify(dec_cur.kind, rd_byte, regs_ff.p);
                  regs_in.p = mr.p;
                  run_in.wr_addr[0] = oa_ff;
                  run_in.wr_data[0] = mr.r;
                  run_in.wr_cnt = 2'd1;
               end else begin
                  regs_in = cpu65_pkg::exec_read(dec_cur.kind, rd_byte, regs_ff);
               end
               fin_req = 1'b1;
            end
            cpu65_pkg::PH_PL1: begin
               case (dec_cur.kind)
                  cpu65_pkg::K_PLA: begin
                     regs_in.a = rd_byte;
                     regs_in.p = cpu65_pkg::set_nz(regs_ff.p, rd_byte);
                     fin_req = 1'b1;
                  end
                  cpu65_pkg::K_PLP: begin
                     regs_in.p = rd_byte | 8'h20;
                     fin_req = 1'b1;
                  end
                  cpu65_pkg::K_RTI: begin
                     regs_in.p = rd_byte | 8'h20;
                     sp_in = sp_ff + 8'd1;
                     run_in.rd_addr = {cpu65_pkg::STACK_PAGE, sp_in};
                     ph_in = cpu65_pkg::PH_PL2;
                  end
                  cpu65_pkg::K_RTS: begin
                     oa_in = {8'h00, rd_byte};
                     sp_in = sp_ff + 8'd1;
                     run_in.rd_addr = {cpu65_pkg::STACK_PAGE, sp_in};
                     ph_in = cpu65_pkg::PH_PL2;
                  end
                  default: fin_req = 1'b1;
               endcase
            end
            cpu65_pkg::PH_PL2: begin
               if (dec_cur.kind == cpu65_pkg::K_RTI) begin
                  oa_in = {8'h00, rd_byte};
                  sp_in = sp_ff + 8'd1;
                  run_in.rd_addr = {cpu65_pkg::STACK_PAGE, sp_in};
                  ph_in = cpu65_pkg::PH_PL3;
               end else begin
                  pc_in = {rd_byte, oa_ff[7:0]} + 16'd1;
                  fin_req = 1'b1;
               end
            end
            cpu65_pkg::PH_PL3: begin
               pc_in = {rd_byte, oa_ff[7:0]};
               fin_req = 1'b1;
            end
            default: begin
               if (req_data.nmi_request) begin
                  run_in.nmi = 1'b1;
                  ent_req = 1'b1;
                  ent_vec = cpu65_pkg::NMI_VECTOR;
               end else if (req_data.irq_request && !regs_ff.p[2]) begin
                  run_in.irq = 1'b1;
                  ent_req = 1'b1;
               end else begin
                  op_in = rd_byte;
                  pc_in = pc_ff + 16'd1;
                  tally_in = '0;
                  cy_sel = dec_new.cycles;
                  if (!dec_new.valid) begin
                     run_in.bad = 1'b1;
                     run_in.rd_addr = pc_in;
                     ph_in = cpu65_pkg::PH_OPC;
                  end else if (dec_new.mode == cpu65_pkg::M_IMP) begin
                     fin_req = 1'b1;
                     case (dec_new.kind)
                        cpu65_pkg::K_BRK: begin
                           pc_in = pc_in + 16'd1;
                           fin_req = 1'b0;
                           ent_req = 1'b1;
                           ent_brk = 1'b1;
                        end
                        cpu65_pkg::K_RTI, cpu65_pkg::K_RTS,
                        cpu65_pkg::K_PLA, cpu65_pkg::K_PLP: begin
                           fin_req = 1'b0;
                           sp_in = sp_ff + 8'd1;
                           run_in.rd_addr = {cpu65_pkg::STACK_PAGE, sp_in};
                           ph_in = cpu65_pkg::PH_PL1;
                        end
                        cpu65_pkg::K_PHP: begin
                           regs_in.p[4] = 1'b1;
                           run_in.wr_addr[0] = {cpu65_pkg::STACK_PAGE, sp_ff};
                           run_in.wr_data[0] = regs_in.p;
                           run_in.wr_cnt = 2'd1;
                           sp_in = sp_ff - 8'd1;
                        end
                        cpu65_pkg::K_PHA: begin
                           run_in.wr_addr[0] = {cpu65_pkg::STACK_PAGE, sp_ff};
                           run_in.wr_data[0] = regs_ff.a;
                           run_in.wr_cnt = 2'd1;
                           sp_in = sp_ff - 8'd1;
                        end
                        cpu65_pkg::K_ASL, cpu65_pkg::K_ROL,
                        cpu65_pkg::K_LSR, cpu65_pkg::K_ROR: begin
                           mr = cpu65_pkg::modify(dec_new.kind, regs_ff.a, regs_ff.p);
                           regs_in.a = mr.r;
                           regs_in.p = mr.p;
                        end
                        cpu65_pkg::K_CLC: regs_in.p[0] = 1'b0;
                        cpu65_pkg::K_SEC: regs_in.p[0] = 1'b1;
                        cpu65_pkg::K_CLI: regs_in.p[2] = 1'b0;
                        cpu65_pkg::K_SEI: regs_in.p[2] = 1'b1;
                        cpu65_pkg::K_CLV: regs_in.p[6] = 1'b0;
                        cpu65_pkg::K_CLD: regs_in.p[3] = 1'b0;
                        cpu65_pkg::K_SED: regs_in.p[3] = 1'b1;
                        cpu65_pkg::K_TXA: begin
                           regs_in.a = regs_ff.x;
                           regs_in.p = cpu65_pkg::set_nz(regs_ff.p, regs_ff.x);
                        end
                        cpu65_pkg::K_TYA: begin
                           regs_in.a = regs_ff.y;
                           regs_in.p = cpu65_pkg::set_nz(regs_ff.p, regs_ff.y);
                        end
                        cpu65_pkg::K_TXS: sp_in = regs_ff.x;
                        cpu65_pkg::K_TAY: begin
                           regs_in.y = regs_ff.a;
                           regs_in.p = cpu65_pkg::set_nz(regs_ff.p, regs_ff.a);
                        end
                        cpu65_pkg::K_TAX: begin
                           regs_in.x = regs_ff.a;
                           regs_in.p = cpu65_pkg::set_nz(regs_ff.p, regs_ff.a);
                        end
                        cpu65_pkg::K_TSX: begin
                           regs_in.x = sp_ff;
                           regs_in.p = cpu65_pkg::set_nz(regs_ff.p, sp_ff);
                        end
                        cpu65_pkg::K_DEX: begin
                           regs_in.x = regs_ff.x - 8'd1;
                           regs_in.p = cpu65_pkg::set_nz(regs_ff.p, regs_in.x);
                        end
                        cpu65_pkg::K_DEY: begin
                           regs_in.y = regs_ff.y - 8'd1;
                           regs_in.p = cpu65_pkg::set_nz(regs_ff.p, regs_in.y);
                        end
                        cpu65_pkg::K_INX: begin
                           regs_in.x = regs_ff.x + 8'd1;
                           regs_in.p = cpu65_pkg::set_nz(regs_ff.p, regs_in.x);
                        end
                        cpu65_pkg::K_INY: begin
                           regs_in.y = regs_ff.y + 8'd1;
                           regs_in.p = cpu65_pkg::set_nz(regs_ff.p, regs_in.y);
                        end
                        default: fin_req = 1'b1;
                     endcase
                  end else begin
                     run_in.rd_addr = pc_in;
                     ph_in = cpu65_pkg::PH_OP1;
                  end
               end
            end
         endcase

         if (acc_req) begin
            oa_in = acc_addr;
            if (dec_cur.kind == cpu65_pkg::K_STA || dec_cur.kind == cpu65_pkg::K_STX ||
                dec_cur.kind == cpu65_pkg::K_STY) begin
               run_in.wr_addr[0] = acc_addr;
               if (dec_cur.kind == cpu65_pkg::K_STA) begin
                  run_in.wr_data[0] = regs_ff.a;
               end else if (dec_cur.kind == cpu65_pkg::K_STX) begin
                  run_in.wr_data[0] = regs_ff.x;
               end else begin
                  run_in.wr_data[0] = regs_ff.y;
               end
               run_in.wr_cnt = 2'd1;
               fin_req = 1'b1;
            end else begin
               run_in.rd_addr = acc_addr;
               ph_in = cpu65_pkg::PH_DAT;
            end
         end
         if (fin_req) begin
            run_in.done = 1'b1;
            run_in.cyc = cy_sel + tally_in;
            run_in.rd_addr = pc_in;
            ph_in = cpu65_pkg::PH_OPC;
         end
         if (ent_req) begin
            regs_in.p[4] = ent_brk;
            run_in.wr_addr[0] = {cpu65_pkg::STACK_PAGE, sp_ff};
            run_in.wr_data[0] = pc_in[15:8];
            run_in.wr_addr[1] = {cpu65_pkg::STACK_PAGE, 8'(sp_ff - 8'd1)};
            run_in.wr_data[1] = pc_in[7:0];
            run_in.wr_addr[2] = {cpu65_pkg::STACK_PAGE, 8'(sp_ff - 8'd2)};
            run_in.wr_data[2] = regs_in.p;
            run_in.wr_cnt = 2'd3;
            sp_in = sp_ff - 8'd3;
            regs_in.p[2] = 1'b1;
            pt_in = ent_vec;
            run_in.rd_addr = ent_vec;
            ph_in = cpu65_pkg::PH_VLO;
         end
      end
   end

   assign last_item = (idx_ff == run_ff.wr_cnt);
   assign rsp_valid = pend_ff;
   assign req_ready = !pend_ff || (rsp_ready && last_item);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      rsp_data = '0;
      if (!last_item) begin
         rsp_data.bus_address = run_ff.wr_addr[idx_ff];
         rsp_data.bus_write_data = run_ff.wr_data[idx_ff];
         rsp_data.bus_is_write = 1'b1;
      end else begin
         rsp_data.bus_address = run_ff.rd_addr;
         rsp_data.last_access = 1'b1;
         rsp_data.instr_done = run_ff.done;
         rsp_data.instr_cycles = run_ff.cyc;
         rsp_data.bad_opcode = run_ff.bad;
         rsp_data.nmi_taken = run_ff.nmi;
         rsp_data.irq_taken = run_ff.irq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.a <= 8'h00;
         regs_ff.x <= 8'h00;
         regs_ff.y <= 8'h00;
         regs_ff.p <= cpu65_pkg::P_RESET;
         sp_ff <= cpu65_pkg::SP_RESET;
         pc_ff <= '0;
         op_ff <= '0;
         ph_ff <= cpu65_pkg::PH_VLO;
         oa_ff <= '0;
         pt_ff <= cpu65_pkg::RESET_VECTOR;
         tally_ff <= '0;
         pend_ff <= 1'b0;
         idx_ff <= '0;
      end else if (req_take) begin
         regs_ff <= regs_in;
         sp_ff <= sp_in;
         pc_ff <= pc_in;
         op_ff <= op_in;
         ph_ff <= ph_in;
         oa_ff <= oa_in;
         pt_ff <= pt_in;
         tally_ff <= tally_in;
         pend_ff <= 1'b1;
         idx_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         if (last_item) begin
            pend_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         run_ff <= run_in;
      end
   end

endmodule

/* tb/tb_cpu_6502_core_top.sv */
// Self-checking testbench for cpu_6502_core_top: feeds bus read returns, resets and
// interrupt lines, predicts every bus access of each run and compares them in order.
// Depends on cpu65_pkg and cpu_6502_core_top.
module tb_cpu_6502_core_top;

   typedef struct {
      bit                  ok;
      cpu65_pkg::mode_type md;
      cpu65_pkg::kind_type kd;
      bit [3:0]            cy;
   } op_info_type;

   typedef struct {
      bit        act;
      bit [7:0]  data;
      bit        nmi;
      bit        irq;
      bit [15:0] addr;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   cpu65_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   cpu65_pkg::rsp_type rsp_data;

   cpu_6502_core_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Predicted CPU state.
   bit [7:0]             acc, xr, yr, sp, pf, cur_op;
   bit [15:0]            pc, oper_addr, ptr;
   bit [3:0]             tally;
   cpu65_pkg::phase_type phase;
   bit                   f_done, f_bad, f_nmi, f_irq;
   bit [3:0]             f_cyc;
   cpu65_pkg::rsp_type   run_q[$];
   cpu65_pkg::rsp_type   pending_accesses[$];

   int  errors = 0;
   int  n_req = 0, n_acc = 0, n_instr = 0, n_int = 0;
   int  idle_pct = 0, stall_pct = 0, hold_cnt = 0;
   bit  hold_req = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   function automatic op_info_type decode_op(input bit [7:0] op);
      op_info_type         r;
      bit [2:0]            a, b;
      bit [3:0]            cyc_alu[8];
      cpu65_pkg::mode_type md_alu[8];
      cpu65_pkg::kind_type k_flag[8], k_stk[8];
      bit [3:0]            cyc_stk[8];
      cyc_alu = '{4'd6, 4'd3, 4'd2, 4'd4, 4'd5, 4'd4, 4'd4, 4'd4};
      md_alu = '{cpu65_pkg::M_IZX, cpu65_pkg::M_ZP, cpu65_pkg::M_IMM, cpu65_pkg::M_ABS,
                 cpu65_pkg::M_IZY, cpu65_pkg::M_ZPX, cpu65_pkg::M_ABY, cpu65_pkg::M_ABX};
      k_flag = '{cpu65_pkg::K_CLC, cpu65_pkg::K_SEC, cpu65_pkg::K_CLI, cpu65_pkg::K_SEI,
                 cpu65_pkg::K_TYA, cpu65_pkg::K_CLV, cpu65_pkg::K_CLD, cpu65_pkg::K_SED};
      k_stk = '{cpu65_pkg::K_PHP, cpu65_pkg::K_PLP, cpu65_pkg::K_PHA, cpu65_pkg::K_PLA,
                cpu65_pkg::K_DEY, cpu65_pkg::K_TAY, cpu65_pkg::K_INY, cpu65_pkg::K_INX};
      cyc_stk = '{4'd3, 4'd4, 4'd3, 4'd4, 4'd2, 4'd2, 4'd2, 4'd2};
      a = op[7:5];
      b = op[4:2];
      r = '{1'b1, cpu65_pkg::M_IMP, cpu65_pkg::K_ORA, 4'd2};
      case (op[1:0])
         2'd1: begin
            r.ok = (op != 8'h89);
            r.kd = {3'b000, a};
            r.md = md_alu[b];
            r.cy = (a == 3'd4 && b == 3'd4) ? 4'd6 : cyc_alu[b];
         end
         2'd2: begin
            r.kd = {3'b001, a};
            case (b)
               3'd0: begin r.ok = (op == 8'ha2); r.md = cpu65_pkg::M_IMM; end
               3'd1: begin
                  r.md = cpu65_pkg::M_ZP;
                  r.cy = (a == 3'd4 || a == 3'd5) ? 4'd3 : 4'd5;
               end
               3'd2: begin
                  if (a == 3'd4) r.kd = cpu65_pkg::K_TXA;
                  else if (a == 3'd5) r.kd = cpu65_pkg::K_TAX;
                  else if (a == 3'd6) r.kd = cpu65_pkg::K_DEX;
                  else if (a == 3'd7) r.kd = cpu65_pkg::K_NOP;
               end
               3'd3: begin
                  r.md = cpu65_pkg::M_ABS;
                  r.cy = (a == 3'd4 || a == 3'd5) ? 4'd4 : 4'd6;
               end
               3'd5: begin
                  if (a == 3'd4 || a == 3'd5) begin r.md = cpu65_pkg::M_ZPY; r.cy = 4'd4; end
                  else begin r.md = cpu65_pkg::M_ZPX; r.cy = 4'd6; end
               end
               3'd6: begin
                  if (op == 8'h9a) r.kd = cpu65_pkg::K_TXS;
                  else if (op == 8'hba) r.kd = cpu65_pkg::K_TSX;
                  else r.ok = 0;
               end
               3'd7: begin
                  if (a == 3'd4) r.ok = 0;
                  else if (a == 3'd5) begin r.md = cpu65_pkg::M_ABY; r.cy = 4'd4; end
                  else begin
                     r.md = cpu65_pkg::M_ABX;
                     r.cy = (a < 3'd4) ? 4'd6 : 4'd7;
                  end
               end
               default: r.ok = 0;
            endcase
         end
         2'd3: r.ok = 0;
         default: begin
            if (b == 3'd4) begin r.md = cpu65_pkg::M_REL; r.kd = cpu65_pkg::K_BR; end
            else if (b == 3'd6) r.kd = k_flag[a];
            else if (b == 3'd2) begin r.kd = k_stk[a]; r.cy = cyc_stk[a]; end
            else if (b == 3'd0) begin
               case (a)
                  3'd0: begin r.kd = cpu65_pkg::K_BRK; r.cy = 4'd7; end
                  3'd1: begin
                     r.md = cpu65_pkg::M_ABS; r.kd = cpu65_pkg::K_JSR; r.cy = 4'd6;
                  end
                  3'd2: begin r.kd = cpu65_pkg::K_RTI; r.cy = 4'd6; end
                  3'd3: begin r.kd = cpu65_pkg::K_RTS; r.cy = 4'd6; end
                  3'd5: begin r.md = cpu65_pkg::M_IMM; r.kd = cpu65_pkg::K_LDY; end
                  3'd6: begin r.md = cpu65_pkg::M_IMM; r.kd = cpu65_pkg::K_CPY; end
                  3'd7: begin r.md = cpu65_pkg::M_IMM; r.kd = cpu65_pkg::K_CPX; end
                  default: r.ok = 0;
               endcase
            end else if (op == 8'h4c) begin
               r.md = cpu65_pkg::M_ABS; r.kd = cpu65_pkg::K_JMP; r.cy = 4'd3;
            end else if (op == 8'h6c) begin
               r.md = cpu65_pkg::M_IND; r.kd = cpu65_pkg::K_JMP; r.cy = 4'd5;
            end else begin
               case (a)
                  3'd1: r.kd = cpu65_pkg::K_BIT;
                  3'd4: r.kd = cpu65_pkg::K_STY;
                  3'd5: r.kd = cpu65_pkg::K_LDY;
                  3'd6: r.kd = cpu65_pkg::K_CPY;
                  3'd7: r.kd = cpu65_pkg::K_CPX;
                  default: r.ok = 0;
               endcase
               if (b == 3'd1) begin r.md = cpu65_pkg::M_ZP; r.cy = 4'd3; end
               else if (b == 3'd3) begin r.md = cpu65_pkg::M_ABS; r.cy = 4'd4; end
               else if (b == 3'd5 && (a == 3'd4 || a == 3'd5)) begin
                  r.md = cpu65_pkg::M_ZPX; r.cy = 4'd4;
               end else if (b == 3'd7 && a == 3'd5) begin
                  r.md = cpu65_pkg::M_ABX; r.cy = 4'd4;
               end else r.ok = 0;
            end
         end
      endcase
      return r;
   endfunction

   function automatic void clear_state();
      acc = 0; xr = 0; yr = 0; sp = cpu65_pkg::SP_RESET; pc = 0; pf = cpu65_pkg::P_RESET;
      cur_op = 0; phase = cpu65_pkg::PH_VLO; oper_addr = 0;
      ptr = cpu65_pkg::RESET_VECTOR; tally = 0;
   endfunction

   function automatic void emit(input bit [15:0] addr, input bit [7:0] wd, input bit wr,
                                input bit last);
      cpu65_pkg::rsp_type e;
      e = '0;
      e.bus_address = addr;
      e.bus_write_data = wr ? wd : 8'h00;
      e.bus_is_write = wr;
      e.last_access = last;
      if (run_q.size() < 4) run_q.push_back(e);
   endfunction

   function automatic void set_nz(input bit [7:0] v);
      pf = {v[7], pf[6:2], v == 8'h00, pf[0]};
   endfunction

   function automatic void push8(input bit [7:0] v);
      emit({8'h01, sp}, v, 1'b1, 1'b0);
      sp--;
   endfunction

   function automatic void pull_next(input cpu65_pkg::phase_type nxt);
      sp++;
      emit({8'h01, sp}, 8'h00, 1'b0, 1'b1);
      phase = nxt;
   endfunction

   function automatic void fetch_next();
      emit(pc, 8'h00, 1'b0, 1'b1);
      phase = cpu65_pkg::PH_OPC;
   endfunction

   function automatic void finish_instr(input bit [3:0] cy);
      f_done = 1;
      f_cyc = cy + tally;
      fetch_next();
   endfunction

   function automatic void enter_int(input bit [15:0] vec, input bit brk);
      pf[4] = brk;
      push8(pc[15:8]);
      push8(pc[7:0]);
      push8(pf);
      pf[2] = 1;
      ptr = vec;
      emit(vec, 8'h00, 1'b0, 1'b1);
      phase = cpu65_pkg::PH_VLO;
   endfunction

   function automatic void compare_reg(input bit [7:0] r, input bit [7:0] v);
      bit [7:0] diff;
      diff = r - v;
      pf[0] = (r >= v);
      set_nz(diff);
   endfunction

   function automatic void alu_read(input cpu65_pkg::kind_type kd, input bit [7:0] v);
      bit [9:0] s;
      bit       c;
      c = pf[0];
      case (kd)
         cpu65_pkg::K_ORA: begin acc = acc | v; set_nz(acc); end
         cpu65_pkg::K_AND: begin acc = acc & v; set_nz(acc); end
         cpu65_pkg::K_EOR: begin acc = acc ^ v; set_nz(acc); end
         cpu65_pkg::K_ADC: begin
            s = {2'b00, acc} + {2'b00, v} + {9'h000, c};
            pf[6] = ~(acc[7] ^ v[7]) & (acc[7] ^ s[7]);
            pf[0] = s[8];
            acc = s[7:0]; set_nz(acc);
         end
         cpu65_pkg::K_LDA: begin acc = v; set_nz(v); end
         cpu65_pkg::K_CMP: compare_reg(acc, v);
         cpu65_pkg::K_SBC: begin
            s = ({2'b00, acc} + 10'h100 - {2'b00, v} - {9'h000, ~c}) & 10'h1ff;
            pf[6] = (acc[7] ^ s[7]) & (acc[7] ^ v[7]);
            pf[0] = s[8];
            acc = s[7:0]; set_nz(acc);
         end
         cpu65_pkg::K_LDX: begin xr = v; set_nz(v); end
         cpu65_pkg::K_LDY: begin yr = v; set_nz(v); end
         cpu65_pkg::K_CPX: compare_reg(xr, v);
         cpu65_pkg::K_CPY: compare_reg(yr, v);
         cpu65_pkg::K_BIT: begin pf[7:6] = v[7:6]; pf[1] = ((acc & v) == 8'h00); end
         default: ;
      endcase
   endfunction

   function automatic bit [7:0] shift_op(input cpu65_pkg::kind_type kd, input bit [7:0] v);
      bit [7:0] r;
      case (kd)
         cpu65_pkg::K_ASL: begin r = {v[6:0], 1'b0}; pf[0] = v[7]; end
         cpu65_pkg::K_ROL: begin r = {v[6:0], pf[0]}; pf[0] = v[7]; end
         cpu65_pkg::K_LSR: begin r = {1'b0, v[7:1]}; pf[0] = v[0]; end
         cpu65_pkg::K_ROR: begin r = {pf[0], v[7:1]}; pf[0] = v[0]; end
         cpu65_pkg::K_DEC: r = v - 8'd1;
         default: r = v + 8'd1;
      endcase
      set_nz(r);
      return r;
   endfunction

   function automatic void mem_access(input bit [15:0] addr, input cpu65_pkg::kind_type kd,
                                      input bit [3:0] cy);
      oper_addr = addr;
      if (kd == cpu65_pkg::K_STA) begin emit(addr, acc, 1'b1, 1'b0); finish_instr(cy); end
      else if (kd == cpu65_pkg::K_STX) begin emit(addr, xr, 1'b1, 1'b0); finish_instr(cy); end
      else if (kd == cpu65_pkg::K_STY) begin emit(addr, yr, 1'b1, 1'b0); finish_instr(cy); end
      else begin emit(addr, 8'h00, 1'b0, 1'b1); phase = cpu65_pkg::PH_DAT; end
   endfunction

   function automatic void run_implied(input cpu65_pkg::kind_type kd, input bit [3:0] cy);
      case (kd)
         cpu65_pkg::K_BRK: begin pc++; enter_int(cpu65_pkg::IRQ_VECTOR, 1'b1); return; end
         cpu65_pkg::K_RTI, cpu65_pkg::K_RTS, cpu65_pkg::K_PLA, cpu65_pkg::K_PLP: begin
            pull_next(cpu65_pkg::PH_PL1);
            return;
         end
         cpu65_pkg::K_PHP: begin pf[4] = 1; push8(pf); end
         cpu65_pkg::K_PHA: push8(acc);
         cpu65_pkg::K_ASL, cpu65_pkg::K_ROL, cpu65_pkg::K_LSR, cpu65_pkg::K_ROR:
            acc = shift_op(kd, acc);
         cpu65_pkg::K_CLC: pf[0] = 0;
         cpu65_pkg::K_SEC: pf[0] = 1;
         cpu65_pkg::K_CLI: pf[2] = 0;
         cpu65_pkg::K_SEI: pf[2] = 1;
         cpu65_pkg::K_CLV: pf[6] = 0;
         cpu65_pkg::K_CLD: pf[3] = 0;
         cpu65_pkg::K_SED: pf[3] = 1;
         cpu65_pkg::K_TXA: begin acc = xr; set_nz(acc); end
         cpu65_pkg::K_TYA: begin acc = yr; set_nz(acc); end
         cpu65_pkg::K_TXS: sp = xr;
         cpu65_pkg::K_TAY: begin yr = acc; set_nz(yr); end
         cpu65_pkg::K_TAX: begin xr = acc; set_nz(xr); end
         cpu65_pkg::K_TSX: begin xr = sp; set_nz(xr); end
         cpu65_pkg::K_DEX: begin xr--; set_nz(xr); end
         cpu65_pkg::K_DEY: begin yr--; set_nz(yr); end
         cpu65_pkg::K_INX: begin xr++; set_nz(xr); end
         cpu65_pkg::K_INY: begin yr++; set_nz(yr); end
         default: ;
      endcase
      finish_instr(cy);
   endfunction

   // Computes the bus run caused by one request transaction and queues it.
   function automatic void predict_bus_run(input cpu65_pkg::req_type r);
      op_info_type di;
      bit [7:0]    d;
      bit [15:0]   t, v, ab;
      bit          taken;
      bit [2:0]    a;
      d = r.read_data;
      run_q.delete();
      f_done = 0; f_cyc = 0; f_bad = 0; f_nmi = 0; f_irq = 0;
      di = decode_op(cur_op);
      if (!r.action) begin
         clear_state();
         emit(cpu65_pkg::RESET_VECTOR, 8'h00, 1'b0, 1'b1);
      end else begin
         case (phase)
            cpu65_pkg::PH_VLO: begin
               oper_addr = {8'h00, d};
               emit(ptr + 16'd1, 8'h00, 1'b0, 1'b1);
               phase = cpu65_pkg::PH_VHI;
            end
            cpu65_pkg::PH_VHI: begin
               pc = {d, oper_addr[7:0]};
               if (ptr == cpu65_pkg::RESET_VECTOR) pc[15] = 1;
               else begin f_done = 1; f_cyc = 4'd7; end
               fetch_next();
            end
            cpu65_pkg::PH_OP1: begin
               pc++;
               case (di.md)
                  cpu65_pkg::M_IMM: begin alu_read(di.kd, d); finish_instr(di.cy); end
                  cpu65_pkg::M_ZP: mem_access({8'h00, d}, di.kd, di.cy);
                  cpu65_pkg::M_ZPX: mem_access({8'h00, 8'(d + xr)}, di.kd, di.cy);
                  cpu65_pkg::M_ZPY: mem_access({8'h00, 8'(d + yr)}, di.kd, di.cy);
                  cpu65_pkg::M_REL: begin
                     t = pc + {{8{d[7]}}, d};
                     if (t[15:8] != pc[15:8]) tally++;
                     a = cur_op[7:5];
                     case (a[2:1])
                        2'd0: taken = pf[7];
                        2'd1: taken = pf[6];
                        2'd2: taken = pf[0];
                        default: taken = pf[1];
                     endcase
                     if (taken == a[0]) begin pc = t; tally++; end
                     finish_instr(di.cy);
                  end
                  cpu65_pkg::M_IZX, cpu65_pkg::M_IZY: begin
                     ptr = (di.md == cpu65_pkg::M_IZX) ? {8'h00, 8'(d + xr)} : {8'h00, d};
                     emit(ptr, 8'h00, 1'b0, 1'b1);
                     phase = cpu65_pkg::PH_PLO;
                  end
                  default: begin
                     oper_addr = {8'h00, d};
                     emit(pc, 8'h00, 1'b0, 1'b1);
                     phase = cpu65_pkg::PH_OP2;
                  end
               endcase
            end
            cpu65_pkg::PH_OP2: begin
               ab = {d, oper_addr[7:0]};
               pc++;
               if (di.kd == cpu65_pkg::K_JSR) begin
                  t = pc - 16'd1;
                  push8(t[15:8]);
                  push8(t[7:0]);
                  pc = ab;
                  finish_instr(di.cy);
               end else if (di.md == cpu65_pkg::M_IND) begin
                  ptr = ab; emit(ab, 8'h00, 1'b0, 1'b1); phase = cpu65_pkg::PH_PLO;
               end else if (di.kd == cpu65_pkg::K_JMP) begin
                  pc = ab; finish_instr(di.cy);
               end else if (di.md == cpu65_pkg::M_ABX || di.md == cpu65_pkg::M_ABY) begin
                  t = ab + {8'h00, (di.md == cpu65_pkg::M_ABX) ? xr : yr};
                  if (t[15:8] != ab[15:8]) tally++;
                  mem_access(t, di.kd, di.cy);
               end else mem_access(ab, di.kd, di.cy);
            end
            cpu65_pkg::PH_PLO: begin
               oper_addr = {8'h00, d};
               emit({ptr[15:8], 8'(ptr[7:0] + 8'd1)}, 8'h00, 1'b0, 1'b1);
               phase = cpu65_pkg::PH_PHI;
            end
            cpu65_pkg::PH_PHI: begin
               v = {d, oper_addr[7:0]};
               if (di.md == cpu65_pkg::M_IZX) begin
                  if (v[15:8] != ptr[15:8]) tally++;
                  mem_access(v, di.kd, di.cy);
               end else if (di.md == cpu65_pkg::M_IZY) begin
                  t = v + {8'h00, yr};
                  if (t[15:8] != v[15:8]) tally++;
                  mem_access(t, di.kd, di.cy);
               end else begin pc = v; finish_instr(di.cy); end
            end
            cpu65_pkg::PH_DAT: begin
               if ((di.kd >= cpu65_pkg::K_ASL && di.kd <= cpu65_pkg::K_ROR) ||
                   di.kd == cpu65_pkg::K_DEC || di.kd == cpu65_pkg::K_INC)
                  emit(oper_addr, shift_op(di.kd, d), 1'b1, 1'b0);
               else alu_read(di.kd, d);
               finish_instr(di.cy);
            end
            cpu65_pkg::PH_PL1: begin
               if (di.kd == cpu65_pkg::K_PLA) begin
                  acc = d; set_nz(d); finish_instr(di.cy);
               end else if (di.kd == cpu65_pkg::K_PLP) begin
                  pf = d | 8'h20; finish_instr(di.cy);
               end else if (di.kd == cpu65_pkg::K_RTI) begin
                  pf = d | 8'h20; pull_next(cpu65_pkg::PH_PL2);
               end else if (di.kd == cpu65_pkg::K_RTS) begin
                  oper_addr = {8'h00, d}; pull_next(cpu65_pkg::PH_PL2);
               end else finish_instr(di.cy);
            end
            cpu65_pkg::PH_PL2: begin
               if (di.kd == cpu65_pkg::K_RTI) begin
                  oper_addr = {8'h00, d}; pull_next(cpu65_pkg::PH_PL3);
               end else begin
                  pc = {d, oper_addr[7:0]} + 16'd1; finish_instr(di.cy);
               end
            end
            cpu65_pkg::PH_PL3: begin pc = {d, oper_addr[7:0]}; finish_instr(di.cy); end
            default: begin
               if (r.nmi_request) begin
                  f_nmi = 1; enter_int(cpu65_pkg::NMI_VECTOR, 1'b0);
               end else if (r.irq_request && !pf[2]) begin
                  f_irq = 1; enter_int(cpu65_pkg::IRQ_VECTOR, 1'b0);
               end else begin
                  cur_op = d;
                  pc++;
                  tally = 0;
                  di = decode_op(d);
                  if (!di.ok) begin f_bad = 1; fetch_next(); end
                  else if (di.md == cpu65_pkg::M_IMP) run_implied(di.kd, di.cy);
                  else begin emit(pc, 8'h00, 1'b0, 1'b1); phase = cpu65_pkg::PH_OP1; end
               end
            end
         endcase
      end
      run_q[run_q.size() - 1].instr_done = f_done;
      run_q[run_q.size() - 1].instr_cycles = f_cyc;
      run_q[run_q.size() - 1].bad_opcode = f_bad;
      run_q[run_q.size() - 1].nmi_taken = f_nmi;
      run_q[run_q.size() - 1].irq_taken = f_irq;
      foreach (run_q[i]) pending_accesses.push_back(run_q[i]);
   endfunction

   task automatic send(input cpu65_pkg::req_type r);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predict_bus_run(r);
      n_req++;
   endtask

   function automatic cpu65_pkg::req_type random_req();
      cpu65_pkg::req_type r;
      op_info_type        di;
      r.action = ($urandom_range(99) != 0);
      r.read_data = 8'($urandom_range(0, 255));
      r.nmi_request = ($urandom_range(99) < 3);
      r.irq_request = ($urandom_range(99) < 10);
      if (phase == cpu65_pkg::PH_OPC && $urandom_range(9) != 0) begin
         di = decode_op(r.read_data);
         while (!di.ok) begin
            r.read_data = 8'($urandom_range(0, 255));
            di = decode_op(r.read_data);
         end
      end
      return r;
   endfunction

   always @(negedge clock) begin
      if (hold_req) begin
         hold_req <= 1'b0;
         hold_cnt <= 200;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cpu65_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_accesses.size() == 0) begin
            report("unexpected access, address", rsp_data.bus_address, 0);
         end else begin
            e = pending_accesses.pop_front();
            n_acc++;
            if (rsp_data.instr_done) n_instr++;
            if (rsp_data.nmi_taken || rsp_data.irq_taken) n_int++;
            if (rsp_data.bus_address !== e.bus_address)
               report("bus_address", rsp_data.bus_address, e.bus_address);
            if (rsp_data.bus_write_data !== e.bus_write_data)
               report("bus_write_data", rsp_data.bus_write_data, e.bus_write_data);
            if (rsp_data.bus_is_write !== e.bus_is_write)
               report("bus_is_write", rsp_data.bus_is_write, e.bus_is_write);
            if (rsp_data.last_access !== e.last_access)
               report("last_access", rsp_data.last_access, e.last_access);
            if (rsp_data.instr_done !== e.instr_done)
               report("instr_done", rsp_data.instr_done, e.instr_done);
            if (rsp_data.instr_cycles !== e.instr_cycles)
               report("instr_cycles", rsp_data.instr_cycles, e.instr_cycles);
            if (rsp_data.bad_opcode !== e.bad_opcode)
               report("bad_opcode", rsp_data.bad_opcode, e.bad_opcode);
            if (rsp_data.nmi_taken !== e.nmi_taken)
               report("nmi_taken", rsp_data.nmi_taken, e.nmi_taken);
            if (rsp_data.irq_taken !== e.irq_taken)
               report("irq_taken", rsp_data.irq_taken, e.irq_taken);
         end
      end
   end

   initial begin
      #5000000;
      $display("tb_cpu_6502_core_top: errors");
      $finish;
   end

   initial begin
      dir_row_type        rows[25];
      cpu65_pkg::req_type r;
      int                 idle_set[4], stall_set[4];
      rows = '{
         '{0, 8'h00, 0, 0, 16'hfffc}, '{1, 8'h00, 0, 0, 16'hfffd},
         '{1, 8'h80, 0, 0, 16'h8000}, '{1, 8'ha9, 0, 0, 16'h8001},
         '{1, 8'hff, 0, 0, 16'h8002}, '{1, 8'h02, 0, 0, 16'h8003},
         '{1, 8'h69, 0, 0, 16'h8004}, '{1, 8'h01, 0, 0, 16'h8005},
         '{1, 8'he9, 0, 0, 16'h8006}, '{1, 8'h80, 0, 0, 16'h8007},
         '{1, 8'h8d, 0, 0, 16'h8008}, '{1, 8'hff, 0, 0, 16'h8009},
         '{1, 8'hff, 0, 0, 16'h800a}, '{1, 8'hea, 1, 0, 16'hfffa},
         '{1, 8'h00, 0, 0, 16'hfffb}, '{1, 8'h90, 0, 0, 16'h9000},
         '{1, 8'h78, 0, 0, 16'h9001}, '{1, 8'hea, 0, 1, 16'h9002},
         '{1, 8'h00, 0, 0, 16'hfffe}, '{1, 8'h34, 0, 0, 16'hffff},
         '{1, 8'h12, 0, 0, 16'h1234}, '{1, 8'h58, 0, 0, 16'h1235},
         '{1, 8'hea, 0, 1, 16'hfffe}, '{1, 8'h00, 0, 0, 16'hffff},
         '{1, 8'hc0, 0, 0, 16'hc000}};
      idle_set = '{0, 82, 0, 35};
      stall_set = '{0, 0, 82, 35};
      clear_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         r = '{rows[i].act, rows[i].data, rows[i].nmi, rows[i].irq};
         send(r);
         if (pending_accesses[pending_accesses.size() - 1].bus_address != rows[i].addr)
            report("directed run end address",
                   pending_accesses[pending_accesses.size() - 1].bus_address, rows[i].addr);
      end
      for (int p = 0; p < 4; p++) begin
         idle_pct = idle_set[p];
         stall_pct = stall_set[p];
         if (p == 0) hold_req = 1'b1;
         for (int k = 0; k < 64; k++) send(random_req());
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_accesses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d request transactions; checked %0d bus accesses,", n_req, n_acc);
      $display("%0d completed instructions and %0d interrupt entries.", n_instr, n_int);
      if (errors == 0) begin
         $display("tb_cpu_6502_core_top: clean");
      end else begin
         $display("tb_cpu_6502_core_top: errors");
      end
      $finish;
   end

endmodule
